// ===== hdl/gdps_pkg.sv =====
// ----------------------------------------------------------------------------
// gdps_pkg: shared definitions for greedy disjoint pivot selection
// widths, reset defaults and the link record passed along the slot chain
// ----------------------------------------------------------------------------
package gdps_pkg;

    localparam int MAX_PICKS_DEF  = 32;
    localparam int INDEX_BITS_DEF = 16;

    localparam int WEIGHT_W  = 32;
    localparam int IDX_IN_W  = 16;
    localparam int SUM_W     = 48;
    localparam int POS_W     = 16;
    localparam int CNT_OUT_W = 6;
    localparam int CFG_W     = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    // token walking down the chain with the collision seen so far
    typedef struct packed {
        logic tok;
        logic hit;
    } link_t;

endpackage

// ===== hdl/gdps_cell.sv =====
// ----------------------------------------------------------------------------
// gdps_cell: one slot of the selected pair store
// holds one (row, col) pair, checks the candidate against it and hands the
// token with its running collision flag to the next slot
// ----------------------------------------------------------------------------
module gdps_cell #(
    parameter int INDEX_BITS = gdps_pkg::INDEX_BITS_DEF,
    parameter int CNT_W      = 6,
    parameter int SLOT       = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gdps_pkg::link_t       link_in,
    output gdps_pkg::link_t       link_out,
    input  logic [INDEX_BITS-1:0] cand_p,
    input  logic [INDEX_BITS-1:0] cand_q,
    input  logic [CNT_W-1:0]      count,
    input  logic                  wr_en
);

    logic [INDEX_BITS-1:0] row_reg;
    logic [INDEX_BITS-1:0] col_reg;
    gdps_pkg::link_t       link_reg;
    gdps_pkg::link_t       link_next;
    logic                  in_use;
    logic                  match;

    // slot holds a pair of the current stream only below the fill count
    assign in_use = count > CNT_W'(SLOT);
    assign match  = (cand_p == row_reg) || (cand_p == col_reg) ||
                    (cand_q == row_reg) || (cand_q == col_reg);

    always_comb
    begin
        link_next.tok = link_in.tok;
        link_next.hit = link_in.hit | (link_in.tok & in_use & match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (count == CNT_W'(SLOT)))
        begin
            row_reg <= cand_p;
            col_reg <= cand_q;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== hdl/greedy_disjoint_pivot_select.sv =====
// ----------------------------------------------------------------------------
// greedy_disjoint_pivot_select: greedy non-colliding pivot pair selection
// picks weight-sorted (p, q) pairs that share no index with earlier picks
// ----------------------------------------------------------------------------
// One candidate beat is taken at a time and yields one result beat. The
// candidate is held in an input register while a token walks down a chain
// of MAX_PICKS slot cells, one cell per cycle, each cell checking the pair
// it stores and passing the collision flag on. Once the token leaves the
// last cell the decision commits, waiting while the previous result still
// sits in the output register, and only then is the next input beat taken.
// The result register is separate, so a new candidate is accepted while a
// finished result still waits. The pair store has no reset: only slots
// below the fill count of the current stream are compared. max_picks must
// be written only while idle.
// ----------------------------------------------------------------------------
module greedy_disjoint_pivot_select #(
    parameter int MAX_PICKS  = gdps_pkg::MAX_PICKS_DEF,
    parameter int INDEX_BITS = gdps_pkg::INDEX_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [gdps_pkg::CFG_W-1:0]           cfg_wdata,
    // candidate channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [gdps_pkg::WEIGHT_W-1:0] weight,
    input  logic                                 weight_invalid,
    input  logic [gdps_pkg::IDX_IN_W-1:0]        row_index,
    input  logic [gdps_pkg::IDX_IN_W-1:0]        col_index,
    input  logic                                 last_entry,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accepted,
    output logic [gdps_pkg::POS_W-1:0]           entry_position,
    output logic [gdps_pkg::CNT_OUT_W-1:0]       picked_count,
    output logic                                 finished,
    output logic signed [gdps_pkg::SUM_W-1:0]    positive_sum,
    output logic signed [gdps_pkg::SUM_W-1:0]    negative_sum
);

    localparam int SUM_W    = gdps_pkg::SUM_W;
    localparam int WEIGHT_W = gdps_pkg::WEIGHT_W;
    localparam int POS_W    = gdps_pkg::POS_W;
    localparam int CFG_W    = gdps_pkg::CFG_W;
    localparam int CNT_OUT_W = gdps_pkg::CNT_OUT_W;
    localparam int CNT_W    = $clog2(MAX_PICKS + 1);
    // common width for comparing the fill count against the limit
    localparam int LW       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] max_picks_reg;

    // held candidate
    logic signed [WEIGHT_W-1:0] w_reg;
    logic                       inv_reg;
    logic [INDEX_BITS-1:0]      p_reg;
    logic [INDEX_BITS-1:0]      q_reg;
    logic                       last_reg;
    logic                       launch_reg;
    logic                       hit_reg;

    // stream state
    logic [CNT_W-1:0]        count_reg;
    logic [POS_W-1:0]        pos_reg;
    logic                    full_reg;
    logic                    seen_neg_reg;
    logic signed [SUM_W-1:0] pos_acc_reg;
    logic signed [SUM_W-1:0] neg_acc_reg;

    // result register
    logic                    out_valid_reg;
    logic                    acc_out_reg;
    logic [POS_W-1:0]        epos_out_reg;
    logic [CNT_OUT_W-1:0]    cnt_out_reg;
    logic                    fin_out_reg;
    logic signed [SUM_W-1:0] psum_out_reg;
    logic signed [SUM_W-1:0] nsum_out_reg;

    // decision logic
    logic [LW-1:0]           limit;
    logic [LW-1:0]           count_ext;
    logic                    room;
    logic                    take;
    logic                    commit;
    logic                    wr_slot;
    logic [CNT_W-1:0]        count_next;
    logic                    full_next;
    logic                    seen_neg_next;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] pos_acc_next;
    logic signed [SUM_W-1:0] neg_acc_next;
    logic                    in_beat;

    gdps_pkg::link_t links [0:MAX_PICKS];

    assign in_beat  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // effective limit is the smaller of the register and the slot count
    assign limit = (LW'(max_picks_reg) < LW'(MAX_PICKS)) ? LW'(max_picks_reg)
                                                          : LW'(MAX_PICKS);
    assign count_ext = LW'(count_reg);
    assign room      = !full_reg && (count_ext < limit);

    // first pick of a stream needs only room, even when invalid
    assign take = room && ((count_reg == '0) || (!inv_reg && !hit_reg));

    // commit once the result register is free
    assign commit  = (state_reg == ST_DECIDE) && (!out_valid_reg || out_ready);
    assign wr_slot = commit && take;

    assign w_ext = SUM_W'(w_reg);

    always_comb
    begin
        count_next    = count_reg;
        seen_neg_next = seen_neg_reg;
        pos_acc_next  = pos_acc_reg;
        neg_acc_next  = neg_acc_reg;
        if (take)
        begin
            count_next = count_reg + CNT_W'(1);
            if (!inv_reg)
            begin
                // a zero weight is not negative
                seen_neg_next = seen_neg_reg | w_reg[WEIGHT_W-1];
                if (seen_neg_next)
                begin
                    neg_acc_next = neg_acc_reg + w_ext;
                end
                else
                begin
                    pos_acc_next = pos_acc_reg + w_ext;
                end
            end
        end
        full_next = full_reg || (LW'(count_next) >= limit);
    end

    // slot chain: token enters the first cell in the cycle after the beat
    assign links[0].tok = launch_reg;
    assign links[0].hit = 1'b0;

    for (genvar i = 0; i < MAX_PICKS; i++)
    begin : g_cell
        gdps_cell #(
            .INDEX_BITS (INDEX_BITS),
            .CNT_W      (CNT_W),
            .SLOT       (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .cand_p   (p_reg),
            .cand_q   (q_reg),
            .count    (count_reg),
            .wr_en    (wr_slot)
        );
    end

    // held candidate payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            w_reg    <= weight;
            inv_reg  <= weight_invalid;
            p_reg    <= row_index[INDEX_BITS-1:0];
            q_reg    <= col_index[INDEX_BITS-1:0];
            last_reg <= last_entry;
        end
        if (links[MAX_PICKS].tok)
        begin
            hit_reg <= links[MAX_PICKS].hit;
        end
    end

    // control, stream state and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_picks_reg <= gdps_pkg::CFG_RESET;
            launch_reg    <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            seen_neg_reg  <= 1'b0;
            pos_acc_reg   <= '0;
            neg_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
            acc_out_reg   <= 1'b0;
            epos_out_reg  <= '0;
            cnt_out_reg   <= '0;
            fin_out_reg   <= 1'b0;
            psum_out_reg  <= '0;
            nsum_out_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_picks_reg <= cfg_wdata;
            end
            launch_reg <= in_beat;
            // result beat stays until taken, reloaded on commit
            out_valid_reg <= commit || (out_valid_reg && !out_ready);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    // token left the last slot: collision flag is final
                    if (links[MAX_PICKS].tok)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (commit)
                    begin
                        state_reg    <= ST_IDLE;
                        acc_out_reg  <= take;
                        epos_out_reg <= pos_reg;
                        cnt_out_reg  <= CNT_OUT_W'(count_next);
                        fin_out_reg  <= full_next || last_reg;
                        psum_out_reg <= pos_acc_next;
                        nsum_out_reg <= neg_acc_next;
                        if (last_reg)
                        begin
                            // end of stream: back to an empty selection
                            count_reg    <= '0;
                            pos_reg      <= '0;
                            full_reg     <= 1'b0;
                            seen_neg_reg <= 1'b0;
                            pos_acc_reg  <= '0;
                            neg_acc_reg  <= '0;
                        end
                        else
                        begin
                            count_reg    <= count_next;
                            pos_reg      <= pos_reg + POS_W'(1);
                            full_reg     <= full_next;
                            seen_neg_reg <= seen_neg_next;
                            pos_acc_reg  <= pos_acc_next;
                            neg_acc_reg  <= neg_acc_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_out_reg;
    assign entry_position = epos_out_reg;
    assign picked_count   = cnt_out_reg;
    assign finished       = fin_out_reg;
    assign positive_sum   = psum_out_reg;
    assign negative_sum   = nsum_out_reg;

endmodule

// ===== hdl/gdps_checker.sv =====
// ----------------------------------------------------------------------------
// gdps_checker: port-level checks for greedy disjoint pivot selection
// watches both channels over time; bound to the top level below
// ----------------------------------------------------------------------------
module gdps_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               accepted,
    input logic [gdps_pkg::POS_W-1:0]         entry_position,
    input logic [gdps_pkg::CNT_OUT_W-1:0]     picked_count,
    input logic                               finished
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted) &&
        $stable(entry_position) && $stable(picked_count) && $stable(finished))
        else $error("result beat changed while stalled");

    // one candidate in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second candidate taken while one is in flight");

    // a pick always leaves a nonzero count
    a_pick_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && accepted |-> picked_count != '0)
        else $error("pick reported with empty selection");

    // an empty selection only refuses a candidate when it is finished
    a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !accepted && picked_count == '0 |-> finished)
        else $error("empty selection refused a candidate");

endmodule

bind greedy_disjoint_pivot_select gdps_checker u_gdps_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .entry_position (entry_position),
    .picked_count   (picked_count),
    .finished       (finished)
);
